>>> hdl/rgb_hsv_color_converter_macros.svh
// Assertion macros used by the checker file of the color converter.
`ifndef RGB_HSV_COLOR_CONVERTER_MACROS_SVH
`define RGB_HSV_COLOR_CONVERTER_MACROS_SVH

// clocked check, off while reset is asserted
`define RHC_ASSERT_CLKD(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// clocked check that also runs during reset
`define RHC_ASSERT_RST(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hdl/rhc_pkg.sv
// Shared types and constants of the RGB/HSV color converter.
`default_nettype none

package rhc_pkg;

	// six register stages, the last one is the output register
	localparam int unsigned NUM_STAGES = 6;
	typedef logic [NUM_STAGES-1:0] stage_en_t;

	localparam logic DIR_RGB2HSV = 1'b0;
	localparam logic DIR_HSV2RGB = 1'b1;

	localparam logic [10:0] HUE_SPAN        = 11'd1536;
	localparam logic [10:0] HUE_GREEN_BASE  = 11'd512;
	localparam logic [10:0] HUE_BLUE_BASE   = 11'd1024;

	// pipelined divider
	localparam int unsigned DIV_NW        = 17;
	localparam int unsigned DIV_DW        = 9;
	localparam int unsigned DIV_QW        = 9;
	localparam int unsigned DIV_STEP      = 3;
	localparam int unsigned DIV_FIRST_STG = 2;

	// floor(y/255) = (y*32897) >> 23 for any 16-bit y
	localparam logic [31:0] RECIP_255  = 32'd32897;
	localparam int unsigned RECIP_SHIFT = 23;

	localparam logic [15:0] FULL_SCALE = 16'd65280;
	localparam logic [23:0] HALF_FULL  = 24'd32640;
	localparam logic [15:0] HALF_UNIT  = 16'd127;

	typedef enum logic [1:0] {
		SEL_RED   = 2'd0,
		SEL_GREEN = 2'd1,
		SEL_BLUE  = 2'd2
	} max_sel_t;

	localparam logic [2:0] SEC_RED     = 3'd0;
	localparam logic [2:0] SEC_YELLOW  = 3'd1;
	localparam logic [2:0] SEC_GREEN   = 3'd2;
	localparam logic [2:0] SEC_CYAN    = 3'd3;
	localparam logic [2:0] SEC_BLUE    = 3'd4;
	localparam logic [2:0] SEC_MAGENTA = 3'd5;

endpackage

`default_nettype wire

>>> hdl/rhc_div.sv
// Three-stage restoring divider, three quotient bits per stage.
`default_nettype none

module rhc_div (
	input  wire                         clk,
	input  wire rhc_pkg::stage_en_t     adv,
	input  wire [rhc_pkg::DIV_NW-1:0]   num,
	input  wire [rhc_pkg::DIV_DW-1:0]   den,
	output logic [rhc_pkg::DIV_QW-1:0]  quo
);
	import rhc_pkg::*;

	typedef struct packed {
		logic [DIV_NW-1:0]   rem;
		logic [DIV_STEP-1:0] q;
	} div_step_t;

	// caller guarantees num < den * 2**DIV_QW
	function automatic div_step_t div_step(logic [DIV_NW-1:0] rem_in,
			logic [DIV_DW-1:0] den_in, int unsigned hi);
		div_step_t res;
		logic [DIV_NW+DIV_DW-1:0] trial;
		int i;
		res.rem = rem_in;
		res.q   = '0;
		for (i = 0; i < int'(DIV_STEP); i++) begin
			trial = {{DIV_NW{1'b0}}, den_in} << (hi - i);
			if ({{DIV_DW{1'b0}}, res.rem} >= trial) begin
				res.rem = res.rem - trial[DIV_NW-1:0];
				res.q[DIV_STEP-1-i] = 1'b1;
			end
		end
		return res;
	endfunction

	div_step_t st_a, st_b, st_c;

	logic [DIV_NW-1:0]     rem_s3, rem_s4;
	logic [DIV_DW-1:0]     den_s3, den_s4;
	logic [DIV_STEP-1:0]   quo_s3;
	logic [2*DIV_STEP-1:0] quo_s4;
	logic [DIV_QW-1:0]     quo_s5;

	always_comb begin
		st_a = div_step(num, den, DIV_QW - 1);
		st_b = div_step(rem_s3, den_s3, DIV_QW - 1 - DIV_STEP);
		st_c = div_step(rem_s4, den_s4, DIV_QW - 1 - 2*DIV_STEP);
	end

	always_ff @(posedge clk) begin
		if (adv[DIV_FIRST_STG]) begin
			rem_s3 <= st_a.rem;
			den_s3 <= den;
			quo_s3 <= st_a.q;
		end
		if (adv[DIV_FIRST_STG+1]) begin
			rem_s4 <= st_b.rem;
			den_s4 <= den_s3;
			quo_s4 <= {quo_s3, st_b.q};
		end
		if (adv[DIV_FIRST_STG+2]) begin
			quo_s5 <= {quo_s4, st_c.q};
		end
	end

	assign quo = quo_s5;

endmodule

`default_nettype wire

>>> hdl/rhc_rgb2hsv.sv
// RGB to HSV datapath: max/min, operand build, two dividers, hue assembly.
`default_nettype none

module rhc_rgb2hsv (
	input  wire                     clk,
	input  wire rhc_pkg::stage_en_t adv,
	input  wire [7:0]               red,
	input  wire [7:0]               green,
	input  wire [7:0]               blue,
	output logic [10:0]             hsv_hue,
	output logic [7:0]              hsv_sat,
	output logic [7:0]              hsv_val
);
	import rhc_pkg::*;

	// stage 1
	logic [7:0] mx_c, mn_c, pa_c, pb_c;
	max_sel_t   sel_c;
	logic [7:0] mx_s1, mn_s1, pa_s1, pb_s1;
	max_sel_t   sel_s1;

	always_comb begin
		mn_c = (red < green) ? red : green;
		if (blue < mn_c) begin
			mn_c = blue;
		end
		// ties go to red, then green
		if (red >= green && red >= blue) begin
			sel_c = SEL_RED;
			mx_c  = red;
			pa_c  = green;
			pb_c  = blue;
		end else if (green >= blue) begin
			sel_c = SEL_GREEN;
			mx_c  = green;
			pa_c  = blue;
			pb_c  = red;
		end else begin
			sel_c = SEL_BLUE;
			mx_c  = blue;
			pa_c  = red;
			pb_c  = green;
		end
	end

	always_ff @(posedge clk) begin
		if (adv[0]) begin
			mx_s1  <= mx_c;
			mn_s1  <= mn_c;
			pa_s1  <= pa_c;
			pb_s1  <= pb_c;
			sel_s1 <= sel_c;
		end
	end

	// stage 2: divider operands
	logic [7:0]        d_c, mag_c;
	logic              neg_c;
	logic [DIV_NW-1:0] nsat_c, nhue_c;

	logic [DIV_NW-1:0] nsat_s2, nhue_s2;
	logic [DIV_DW-1:0] dsat_s2, dhue_s2;
	logic [7:0]        mx_s2;
	max_sel_t          sel_s2;
	logic              neg_s2, zd_s2, zm_s2;

	always_comb begin
		d_c   = mx_s1 - mn_s1;
		neg_c = pa_s1 < pb_s1;
		mag_c = neg_c ? (pb_s1 - pa_s1) : (pa_s1 - pb_s1);
		// 2*255*d + mx and 2*256*mag + d, both round-half-up numerators
		nsat_c = ({d_c, 9'd0} - {8'd0, d_c, 1'b0}) + {9'd0, mx_s1};
		nhue_c = {mag_c, 9'd0} + {9'd0, d_c};
	end

	always_ff @(posedge clk) begin
		if (adv[1]) begin
			nsat_s2 <= nsat_c;
			dsat_s2 <= {mx_s1, 1'b0};
			nhue_s2 <= nhue_c;
			dhue_s2 <= {d_c, 1'b0};
			mx_s2   <= mx_s1;
			sel_s2  <= sel_s1;
			neg_s2  <= neg_c;
			zd_s2   <= (d_c == 8'd0);
			zm_s2   <= (mx_s1 == 8'd0);
		end
	end

	// stages 3..5: dividers, side info carried alongside
	logic [DIV_QW-1:0] qsat, qhue;

	rhc_div u_div_sat (
		.clk (clk),
		.adv (adv),
		.num (nsat_s2),
		.den (dsat_s2),
		.quo (qsat)
	);

	rhc_div u_div_hue (
		.clk (clk),
		.adv (adv),
		.num (nhue_s2),
		.den (dhue_s2),
		.quo (qhue)
	);

	logic [7:0] mx_s3, mx_s4, mx_s5;
	max_sel_t   sel_s3, sel_s4, sel_s5;
	logic       neg_s3, neg_s4, neg_s5;
	logic       zd_s3, zd_s4, zd_s5;
	logic       zm_s3, zm_s4, zm_s5;

	always_ff @(posedge clk) begin
		if (adv[2]) begin
			mx_s3  <= mx_s2;
			sel_s3 <= sel_s2;
			neg_s3 <= neg_s2;
			zd_s3  <= zd_s2;
			zm_s3  <= zm_s2;
		end
		if (adv[3]) begin
			mx_s4  <= mx_s3;
			sel_s4 <= sel_s3;
			neg_s4 <= neg_s3;
			zd_s4  <= zd_s3;
			zm_s4  <= zm_s3;
		end
		if (adv[4]) begin
			mx_s5  <= mx_s4;
			sel_s5 <= sel_s4;
			neg_s5 <= neg_s4;
			zd_s5  <= zd_s4;
			zm_s5  <= zm_s4;
		end
	end

	logic [10:0] q_ext;

	always_comb begin
		q_ext = {2'b00, qhue};
		unique case (sel_s5)
			SEL_RED: begin
				if (!neg_s5) begin
					hsv_hue = q_ext;
				end else if (q_ext == 11'd0) begin
					hsv_hue = 11'd0;
				end else begin
					hsv_hue = HUE_SPAN - q_ext;
				end
			end
			SEL_GREEN: hsv_hue = neg_s5 ? (HUE_GREEN_BASE - q_ext) : (HUE_GREEN_BASE + q_ext);
			SEL_BLUE:  hsv_hue = neg_s5 ? (HUE_BLUE_BASE - q_ext) : (HUE_BLUE_BASE + q_ext);
			default:   hsv_hue = 11'd0;
		endcase
		// gray pixel has no hue
		if (zd_s5) begin
			hsv_hue = 11'd0;
		end
		hsv_sat = zm_s5 ? 8'd0 : qsat[7:0];
		hsv_val = mx_s5;
	end

endmodule

`default_nettype wire

>>> hdl/rhc_hsv2rgb.sv
// HSV to RGB datapath: products, reciprocal divides by 255, sector select.
`default_nettype none

module rhc_hsv2rgb (
	input  wire                     clk,
	input  wire rhc_pkg::stage_en_t adv,
	input  wire [10:0]              hue,
	input  wire [7:0]               saturation,
	input  wire [7:0]               brightness,
	output logic [7:0]              rgb_red,
	output logic [7:0]              rgb_green,
	output logic [7:0]              rgb_blue
);
	import rhc_pkg::*;

	// stage 1: sector, S*f, S*(256-f), V*(255-S)
	logic [2:0]  sector_c;
	logic [8:0]  finv_c;
	logic [16:0] a2_full;

	logic [2:0]  sector_s1;
	logic [7:0]  v_s1;
	logic        sz_s1;
	logic [15:0] a1_s1, a2_s1, x1_s1;

	always_comb begin
		// hues 1536 and up wrap into sector 0 or 1; fraction is untouched
		sector_c = (hue[10:9] == 2'b11) ? {2'b00, hue[8]} : hue[10:8];
		finv_c   = 9'd256 - {1'b0, hue[7:0]};
		a2_full  = {9'd0, saturation} * {8'd0, finv_c};
	end

	always_ff @(posedge clk) begin
		if (adv[0]) begin
			sector_s1 <= sector_c;
			v_s1      <= brightness;
			sz_s1     <= (saturation == 8'd0);
			a1_s1     <= {8'd0, saturation} * {8'd0, hue[7:0]};
			a2_s1     <= a2_full[15:0];
			x1_s1     <= {8'd0, brightness} * {8'd0, 8'd255 - saturation};
		end
	end

	// stage 2: V*(65280 - S*f), V*(65280 - S*(256-f)), rounding bias for p1
	logic [2:0]  sector_s2;
	logic [7:0]  v_s2;
	logic        sz_s2;
	logic [23:0] t2_s2, t3_s2;
	logic [15:0] y1_s2;

	always_ff @(posedge clk) begin
		if (adv[1]) begin
			sector_s2 <= sector_s1;
			v_s2      <= v_s1;
			sz_s2     <= sz_s1;
			t2_s2     <= {16'd0, v_s1} * {8'd0, FULL_SCALE - a1_s1};
			t3_s2     <= {16'd0, v_s1} * {8'd0, FULL_SCALE - a2_s1};
			y1_s2     <= x1_s1 + HALF_UNIT;
		end
	end

	// stage 3: p1 = y1/255; fold /65280 into /256 then /255
	logic [31:0] m1_c;
	logic [23:0] u2_c, u3_c;

	logic [2:0]  sector_s3;
	logic [7:0]  v_s3, p1_s3;
	logic        sz_s3;
	logic [15:0] y2_s3, y3_s3;

	always_comb begin
		m1_c = {16'd0, y1_s2} * RECIP_255;
		u2_c = t2_s2 + HALF_FULL;
		u3_c = t3_s2 + HALF_FULL;
	end

	always_ff @(posedge clk) begin
		if (adv[2]) begin
			sector_s3 <= sector_s2;
			v_s3      <= v_s2;
			sz_s3     <= sz_s2;
			p1_s3     <= m1_c[RECIP_SHIFT+7:RECIP_SHIFT];
			y2_s3     <= u2_c[23:8];
			y3_s3     <= u3_c[23:8];
		end
	end

	// stage 4: p2, p3
	logic [31:0] m2_c, m3_c;

	logic [2:0]  sector_s4;
	logic [7:0]  v_s4, p1_s4, p2_s4, p3_s4;
	logic        sz_s4;

	always_comb begin
		m2_c = {16'd0, y2_s3} * RECIP_255;
		m3_c = {16'd0, y3_s3} * RECIP_255;
	end

	always_ff @(posedge clk) begin
		if (adv[3]) begin
			sector_s4 <= sector_s3;
			v_s4      <= v_s3;
			sz_s4     <= sz_s3;
			p1_s4     <= p1_s3;
			p2_s4     <= m2_c[RECIP_SHIFT+7:RECIP_SHIFT];
			p3_s4     <= m3_c[RECIP_SHIFT+7:RECIP_SHIFT];
		end
	end

	// stage 5: route V, p1, p2, p3 by sector
	logic [7:0] r_c, g_c, b_c;
	logic [7:0] r_s5, g_s5, b_s5;

	always_comb begin
		unique case (sector_s4)
			SEC_RED: begin
				r_c = v_s4;  g_c = p3_s4; b_c = p1_s4;
			end
			SEC_YELLOW: begin
				r_c = p2_s4; g_c = v_s4;  b_c = p1_s4;
			end
			SEC_GREEN: begin
				r_c = p1_s4; g_c = v_s4;  b_c = p3_s4;
			end
			SEC_CYAN: begin
				r_c = p1_s4; g_c = p2_s4; b_c = v_s4;
			end
			SEC_BLUE: begin
				r_c = p3_s4; g_c = p1_s4; b_c = v_s4;
			end
			SEC_MAGENTA: begin
				r_c = v_s4;  g_c = p1_s4; b_c = p2_s4;
			end
			default: begin
				r_c = v_s4;  g_c = p1_s4; b_c = p2_s4;
			end
		endcase
		// no saturation: gray at brightness
		if (sz_s4) begin
			r_c = v_s4;
			g_c = v_s4;
			b_c = v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv[4]) begin
			r_s5 <= r_c;
			g_s5 <= g_c;
			b_s5 <= b_c;
		end
	end

	assign rgb_red   = r_s5;
	assign rgb_green = g_s5;
	assign rgb_blue  = b_s5;

endmodule

`default_nettype wire

>>> hdl/rgb_hsv_color_converter.sv
// Top level of the RGB/HSV color converter: pipeline control and output register.
//
// Channel  Handshake             Payload
// in       in_valid / in_stall   red green blue hue saturation brightness
// out      out_valid / out_stall out_red out_green out_blue out_hue out_saturation
//                                out_brightness
// cfg      cfg_wr_en             cfg_wr_data (direction, 0 = RGB->HSV, 1 = HSV->RGB)
//
// One pixel per clock sustained while out_stall is low. The pipeline depth is set
// by the three-stage restoring dividers of the RGB->HSV path, the max/min and
// operand stages ahead of them, and the output register.
// Reset clears all stage valid bits and sets direction to RGB->HSV.
// out_stall holds only full stages; empty stages keep filling, so in_stall rises
// only once the whole pipeline is full.
`default_nettype none

module rgb_hsv_color_converter (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         cfg_wr_en,
	input  wire         cfg_wr_data,
	input  wire         in_valid,
	output logic        in_stall,
	input  wire  [7:0]  red,
	input  wire  [7:0]  green,
	input  wire  [7:0]  blue,
	input  wire  [10:0] hue,
	input  wire  [7:0]  saturation,
	input  wire  [7:0]  brightness,
	output logic        out_valid,
	input  wire         out_stall,
	output logic [7:0]  out_red,
	output logic [7:0]  out_green,
	output logic [7:0]  out_blue,
	output logic [10:0] out_hue,
	output logic [7:0]  out_saturation,
	output logic [7:0]  out_brightness
);
	import rhc_pkg::*;

	logic direction_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			direction_q <= DIR_RGB2HSV;
		end else if (cfg_wr_en) begin
			direction_q <= cfg_wr_data;
		end
	end

	// stage k loads when it is empty or the stage after it moves on
	stage_en_t             adv;
	logic [NUM_STAGES-1:0] vld_q;

	always_comb begin
		adv[NUM_STAGES-1] = !vld_q[NUM_STAGES-1] || !out_stall;
		for (int k = NUM_STAGES - 2; k >= 0; k--) begin
			adv[k] = !vld_q[k] || adv[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (adv[0]) begin
				vld_q[0] <= in_valid;
			end
			for (int k = 1; k < NUM_STAGES; k++) begin
				if (adv[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	assign in_stall = !adv[0];

	// direction travels with each request
	logic dir_s1, dir_s2, dir_s3, dir_s4, dir_s5;

	always_ff @(posedge clk) begin
		if (adv[0]) dir_s1 <= direction_q;
		if (adv[1]) dir_s2 <= dir_s1;
		if (adv[2]) dir_s3 <= dir_s2;
		if (adv[3]) dir_s4 <= dir_s3;
		if (adv[4]) dir_s5 <= dir_s4;
	end

	logic [10:0] hsv_hue;
	logic [7:0]  hsv_sat, hsv_val;
	logic [7:0]  rgb_red, rgb_green, rgb_blue;

	rhc_rgb2hsv u_rgb2hsv (
		.clk     (clk),
		.adv     (adv),
		.red     (red),
		.green   (green),
		.blue    (blue),
		.hsv_hue (hsv_hue),
		.hsv_sat (hsv_sat),
		.hsv_val (hsv_val)
	);

	rhc_hsv2rgb u_hsv2rgb (
		.clk        (clk),
		.adv        (adv),
		.hue        (hue),
		.saturation (saturation),
		.brightness (brightness),
		.rgb_red    (rgb_red),
		.rgb_green  (rgb_green),
		.rgb_blue   (rgb_blue)
	);

	logic [7:0]  red_s6, green_s6, blue_s6, sat_s6, val_s6;
	logic [10:0] hue_s6;

	always_ff @(posedge clk) begin
		if (adv[5]) begin
			if (dir_s5 == DIR_HSV2RGB) begin
				red_s6   <= rgb_red;
				green_s6 <= rgb_green;
				blue_s6  <= rgb_blue;
				hue_s6   <= 11'd0;
				sat_s6   <= 8'd0;
				val_s6   <= 8'd0;
			end else begin
				red_s6   <= 8'd0;
				green_s6 <= 8'd0;
				blue_s6  <= 8'd0;
				hue_s6   <= hsv_hue;
				sat_s6   <= hsv_sat;
				val_s6   <= hsv_val;
			end
		end
	end

	assign out_valid      = vld_q[NUM_STAGES-1];
	assign out_red        = red_s6;
	assign out_green      = green_s6;
	assign out_blue       = blue_s6;
	assign out_hue        = hue_s6;
	assign out_saturation = sat_s6;
	assign out_brightness = val_s6;

endmodule

`default_nettype wire

>>> hdl/rhc_checker.sv
// Port-level checks of the color converter and the bind that attaches them.
`default_nettype none
`include "rgb_hsv_color_converter_macros.svh"

module rhc_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        out_valid,
	input wire        out_stall,
	input wire [7:0]  out_red,
	input wire [7:0]  out_green,
	input wire [7:0]  out_blue,
	input wire [10:0] out_hue,
	input wire [7:0]  out_saturation,
	input wire [7:0]  out_brightness
);

	logic [50:0] res_bus;
	logic        stalled, hsv_zero, rgb_zero, sat_zero;

	assign res_bus  = {out_red, out_green, out_blue, out_hue, out_saturation, out_brightness};
	assign stalled  = out_valid && out_stall;
	assign sat_zero = (out_saturation == 8'd0);
	assign hsv_zero = out_hue == 11'd0 && sat_zero && out_brightness == 8'd0;
	assign rgb_zero = out_red == 8'd0 && out_green == 8'd0 && out_blue == 8'd0;

	// reset clears every valid bit, so nothing shows the cycle after reset
	`RHC_ASSERT_RST(a_no_out_in_reset, !arst_n |=> !out_valid, "result valid during reset")

	`RHC_ASSERT_CLKD(a_out_hold, stalled |=> out_valid && $stable(res_bus), "stalled result changed")

	// one of the two field groups is always zero
	`RHC_ASSERT_CLKD(a_one_group, out_valid |-> hsv_zero || rgb_zero, "both field groups nonzero")

	`RHC_ASSERT_CLKD(a_hue_range, out_valid |-> out_hue < 11'd1536, "hue out of range")

	// zero saturation comes from a gray pixel or an HSV->RGB result, both with hue 0
	`RHC_ASSERT_CLKD(a_gray_hue, out_valid && sat_zero |-> out_hue == 11'd0, "gray pixel with hue")

endmodule

bind rgb_hsv_color_converter rhc_checker u_rhc_checker (.*);

`default_nettype wire

>>> verif/testbench.sv
// Self-checking testbench of the RGB/HSV color converter.
`default_nettype none

module testbench;
	import rhc_pkg::*;

	localparam int TIMEOUT = 4_000_000;

	typedef struct {
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic [10:0] hue;
		logic [7:0]  saturation;
		logic [7:0]  brightness;
		bit          wait_drain;
	} pixel_req_t;

	typedef struct {
		logic [7:0]  out_red;
		logic [7:0]  out_green;
		logic [7:0]  out_blue;
		logic [10:0] out_hue;
		logic [7:0]  out_saturation;
		logic [7:0]  out_brightness;
	} pixel_res_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_wr_en = 1'b0;
	logic        cfg_wr_data = 1'b0;
	logic        in_valid = 1'b0;
	logic [7:0]  red = '0;
	logic [7:0]  green = '0;
	logic [7:0]  blue = '0;
	logic [10:0] hue = '0;
	logic [7:0]  saturation = '0;
	logic [7:0]  brightness = '0;
	logic        out_stall = 1'b0;
	wire         in_stall;
	wire         out_valid;
	wire  [7:0]  out_red;
	wire  [7:0]  out_green;
	wire  [7:0]  out_blue;
	wire  [10:0] out_hue;
	wire  [7:0]  out_saturation;
	wire  [7:0]  out_brightness;

	pixel_req_t pixel_queue[$];
	pixel_res_t expected_pixels[$];
	pixel_req_t driven_req;
	pixel_res_t want;
	logic       cur_direction = DIR_RGB2HSV;
	int         fail_count = 0;
	int         send_gap = 0;
	int         stall_left = 0;
	bit         burst_in = 1'b0;
	bit         burst_out = 1'b0;

	rgb_hsv_color_converter uut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_wr_data    (cfg_wr_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.red            (red),
		.green          (green),
		.blue           (blue),
		.hue            (hue),
		.saturation     (saturation),
		.brightness     (brightness),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.out_red        (out_red),
		.out_green      (out_green),
		.out_blue       (out_blue),
		.out_hue        (out_hue),
		.out_saturation (out_saturation),
		.out_brightness (out_brightness)
	);

	// round(256*n/d), half away from zero
	function automatic int hue_offset(int n, int d);
		int mag;
		int q;
		mag = (n < 0) ? -n : n;
		q = (2 * mag * 256 + d) / (2 * d);
		return (n < 0) ? -q : q;
	endfunction

	function automatic pixel_res_t convert_pixel(logic dir, pixel_req_t q);
		pixel_res_t res;
		int r, g, b, mx, mn, d, hv;
		int h, s, v, f, p1, p2, p3;
		logic [2:0] sector;
		res = '{default: '0};
		if (dir == DIR_RGB2HSV) begin
			r = q.red;
			g = q.green;
			b = q.blue;
			mx = (r > g) ? r : g;
			mn = (r < g) ? r : g;
			if (b > mx) mx = b;
			if (b < mn) mn = b;
			d = mx - mn;
			res.out_brightness = 8'(mx);
			if (mx > 0)
				res.out_saturation = 8'((2 * 255 * d + mx) / (2 * mx));
			// gray and black keep hue 0
			if (d > 0) begin
				if (mx == r) begin
					hv = hue_offset(g - b, d);
					if (hv < 0) hv += HUE_SPAN;
				end else if (mx == g) begin
					hv = HUE_GREEN_BASE + hue_offset(b - r, d);
				end else begin
					hv = HUE_BLUE_BASE + hue_offset(r - g, d);
				end
				res.out_hue = 11'(hv);
			end
		end else begin
			h = q.hue;
			s = q.saturation;
			v = q.brightness;
			if (h >= HUE_SPAN) h -= HUE_SPAN;
			if (s == 0) begin
				res.out_red = 8'(v);
				res.out_green = 8'(v);
				res.out_blue = 8'(v);
			end else begin
				sector = 3'(h / 256);
				f = h % 256;
				p1 = (2 * v * (255 - s) + 255) / 510;
				p2 = (2 * v * (65280 - s * f) + 65280) / 130560;
				p3 = (2 * v * (65280 - s * (256 - f)) + 65280) / 130560;
				case (sector)
					SEC_RED: begin
						res.out_red = 8'(v); res.out_green = 8'(p3); res.out_blue = 8'(p1);
					end
					SEC_YELLOW: begin
						res.out_red = 8'(p2); res.out_green = 8'(v); res.out_blue = 8'(p1);
					end
					SEC_GREEN: begin
						res.out_red = 8'(p1); res.out_green = 8'(v); res.out_blue = 8'(p3);
					end
					SEC_CYAN: begin
						res.out_red = 8'(p1); res.out_green = 8'(p2); res.out_blue = 8'(v);
					end
					SEC_BLUE: begin
						res.out_red = 8'(p3); res.out_green = 8'(p1); res.out_blue = 8'(v);
					end
					default: begin
						res.out_red = 8'(v); res.out_green = 8'(p1); res.out_blue = 8'(p2);
					end
				endcase
			end
		end
		return res;
	endfunction

	// mostly short gaps, a few long ones, none while in burst mode
	function automatic int pick_gap(bit burst);
		int roll;
		if (burst) return 0;
		roll = $urandom_range(0, 99);
		if (roll < 55) return 0;
		if (roll < 90) return $urandom_range(1, 3);
		if (roll < 98) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [7:0] edge_or_any();
		int roll;
		roll = $urandom_range(0, 9);
		if (roll == 0) return 8'd0;
		if (roll == 1) return 8'd255;
		return 8'($urandom);
	endfunction

	function automatic pixel_req_t random_request(logic dir);
		pixel_req_t q;
		int kind;
		q.red = 8'($urandom);
		q.green = 8'($urandom);
		q.blue = 8'($urandom);
		q.hue = 11'($urandom_range(0, 2047));
		q.saturation = 8'($urandom);
		q.brightness = 8'($urandom);
		q.wait_drain = 1'b0;
		kind = $urandom_range(0, 19);
		if (dir == DIR_RGB2HSV) begin
			if (kind < 2) begin
				q.green = q.red;
				q.blue = q.red;
			end else if (kind == 2) begin
				q.green = q.red;
			end else if (kind == 3) begin
				q.blue = q.green;
			end else if (kind == 4) begin
				q.blue = q.red;
			end else if (kind < 7) begin
				q.red = $urandom_range(0, 1) ? 8'd255 : 8'd0;
				q.green = $urandom_range(0, 1) ? 8'd255 : 8'd0;
				q.blue = $urandom_range(0, 1) ? 8'd255 : 8'd0;
			end else if (kind < 9) begin
				q.red = 8'($urandom_range(0, 3));
				q.green = 8'($urandom_range(0, 3));
				q.blue = 8'($urandom_range(0, 3));
			end
		end else begin
			if (kind < 2)
				q.hue = 11'($urandom_range(HUE_SPAN, 2047));
			else if (kind < 4)
				q.hue = 11'($urandom_range(0, 5) * 256 + ($urandom_range(0, 1) ? 255 : 0));
			else
				q.hue = 11'($urandom_range(0, HUE_SPAN - 1));
			q.saturation = edge_or_any();
			q.brightness = edge_or_any();
		end
		return q;
	endfunction

	task automatic add_pixel(int r, int g, int b, int h, int s, int v);
		pixel_req_t q;
		q.red = 8'(r);
		q.green = 8'(g);
		q.blue = 8'(b);
		q.hue = 11'(h);
		q.saturation = 8'(s);
		q.brightness = 8'(v);
		q.wait_drain = 1'b0;
		pixel_queue.push_back(q);
	endtask

	task automatic queue_random(logic dir, int count);
		pixel_req_t q;
		for (int i = 0; i < count; i++) begin
			q = random_request(dir);
			// one request in the middle holds back until the pipeline has drained
			q.wait_drain = (i == count / 2);
			pixel_queue.push_back(q);
		end
	endtask

	task automatic write_direction(logic dir);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= dir;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		cur_direction = dir;
		@(negedge clk);
	endtask

	task automatic wait_idle();
		do
			@(negedge clk);
		while (pixel_queue.size() != 0 || in_valid || expected_pixels.size() != 0);
		repeat (8) @(posedge clk);
	endtask

	task automatic check_field(string name, logic [10:0] exp_val, logic [10:0] got);
		if (got !== exp_val) begin
			$error("%s: expected %0d, got %0d", name, exp_val, got);
			fail_count++;
		end
	endtask

	initial begin
		forever #2 clk = ~clk;
	end

	// request driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				expected_pixels.push_back(convert_pixel(cur_direction, driven_req));
			if ($urandom_range(0, 199) == 0)
				burst_in = !burst_in;
			if (!in_valid || !in_stall) begin
				if (send_gap > 0) begin
					send_gap--;
					in_valid <= 1'b0;
				end else if (pixel_queue.size() != 0 &&
					!(pixel_queue[0].wait_drain && expected_pixels.size() != 0)) begin
					driven_req = pixel_queue.pop_front();
					red <= driven_req.red;
					green <= driven_req.green;
					blue <= driven_req.blue;
					hue <= driven_req.hue;
					saturation <= driven_req.saturation;
					brightness <= driven_req.brightness;
					in_valid <= 1'b1;
					send_gap = pick_gap(burst_in);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor and output stall
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (expected_pixels.size() == 0) begin
					$error("result with no request pending");
					fail_count++;
				end else begin
					want = expected_pixels.pop_front();
					check_field("out_red", 11'(want.out_red), 11'(out_red));
					check_field("out_green", 11'(want.out_green), 11'(out_green));
					check_field("out_blue", 11'(want.out_blue), 11'(out_blue));
					check_field("out_hue", want.out_hue, out_hue);
					check_field("out_saturation", 11'(want.out_saturation),
						11'(out_saturation));
					check_field("out_brightness", 11'(want.out_brightness),
						11'(out_brightness));
				end
			end
			if ($urandom_range(0, 199) == 0)
				burst_out = !burst_out;
			if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
				stall_left = pick_gap(burst_out);
			end
		end
	end

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		write_direction(DIR_RGB2HSV);
		add_pixel(0, 0, 0, 0, 0, 0);
		add_pixel(255, 255, 255, 2047, 255, 255);
		add_pixel(128, 128, 128, 0, 0, 0);
		add_pixel(255, 0, 0, 0, 0, 0);
		add_pixel(0, 255, 0, 0, 0, 0);
		add_pixel(0, 0, 255, 0, 0, 0);
		add_pixel(255, 255, 0, 0, 0, 0);
		add_pixel(0, 255, 255, 0, 0, 0);
		add_pixel(255, 0, 255, 0, 0, 0);
		add_pixel(255, 0, 10, 0, 0, 0);
		add_pixel(1, 0, 0, 0, 0, 0);
		add_pixel(200, 100, 150, 0, 0, 0);
		add_pixel(10, 200, 255, 0, 0, 0);
		wait_idle();

		write_direction(DIR_HSV2RGB);
		add_pixel(0, 0, 0, 0, 0, 200);
		add_pixel(0, 0, 0, 0, 255, 255);
		add_pixel(255, 255, 255, 255, 255, 255);
		add_pixel(0, 0, 0, 256, 255, 255);
		add_pixel(0, 0, 0, 512, 128, 200);
		add_pixel(0, 0, 0, 768, 255, 255);
		add_pixel(0, 0, 0, 1024, 200, 100);
		add_pixel(0, 0, 0, 1280, 255, 255);
		add_pixel(0, 0, 0, 1535, 255, 255);
		add_pixel(0, 0, 0, 1536, 255, 255);
		add_pixel(0, 0, 0, 2047, 1, 255);
		add_pixel(0, 0, 0, 300, 255, 0);
		wait_idle();

		write_direction(DIR_RGB2HSV);
		queue_random(DIR_RGB2HSV, 350);
		wait_idle();
		write_direction(DIR_HSV2RGB);
		queue_random(DIR_HSV2RGB, 375);
		wait_idle();
		write_direction(DIR_RGB2HSV);
		queue_random(DIR_RGB2HSV, 350);
		wait_idle();
		write_direction(DIR_HSV2RGB);
		queue_random(DIR_HSV2RGB, 375);
		wait_idle();
		repeat (20) @(posedge clk);

		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		#(TIMEOUT);
		$display("CHECKS FAILED");
		$finish;
	end

endmodule

`default_nettype wire

>>> files.f
+incdir+hdl
hdl/rhc_pkg.sv
hdl/rhc_div.sv
hdl/rhc_rgb2hsv.sv
hdl/rhc_hsv2rgb.sv
hdl/rgb_hsv_color_converter.sv
hdl/rhc_checker.sv
verif/testbench.sv
